// ===== rtl/core/fpa_pkg.sv =====
package fpa_pkg;

  // Word geometry.
  localparam int DATA_W = 32;
  localparam int FRAC_W = 8;
  localparam int NUM_W  = DATA_W + FRAC_W;
  localparam int FUNC_W = 4;
  localparam int IN_DATA_W  = 2 * DATA_W;
  localparam int OUT_DATA_W = 40;

  // Rounding offset for the multiplier: one half of the last kept bit.
  localparam logic [63:0] MUL_HALF = (FRAC_W > 0) ? (64'd1 << (FRAC_W - 1)) : 64'd0;

  localparam logic [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_CMP      = 4'd4,
    FN_MIN      = 4'd5,
    FN_MAX      = 4'd6,
    FN_INC      = 4'd7,
    FN_DEC      = 4'd8,
    FN_FROM_INT = 4'd9,
    FN_TO_INT   = 4'd10
  } func_t;

  // One word in flight along the pipeline.
  typedef struct packed {
    logic              valid;
    logic [FUNC_W-1:0] func;
    logic              neg;
    logic [DATA_W-1:0] res;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              ovf;
    logic              dz;
    logic [DATA_W-1:0] den;
    logic [DATA_W-1:0] rem;
    logic [NUM_W-1:0]  quo;
  } cell_t;

  // Saturates a signed wide value to 32 bits; returns {overflow, value}.
  function automatic logic [DATA_W:0] sat_s64(input logic signed [63:0] v);
    logic [DATA_W:0] r;
    if (v > 64'(signed'(MAX_VAL))) begin
      r = {1'b1, MAX_VAL};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, MIN_VAL};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  // Applies a sign to a magnitude and saturates; returns {overflow, value}.
  function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [DATA_W:0] r;
    logic [DATA_W-1:0] neg_val;
    neg_val = DATA_W'(64'd0 - mag);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r = {1'b1, MIN_VAL};
      end else begin
        r = {1'b0, neg_val};
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r = {1'b1, MAX_VAL};
      end else begin
        r = {1'b0, mag[DATA_W-1:0]};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/fixed_point_q24_8_alu.sv =====
// Signed Q24.8 ALU on a stream interface.
// Input words arrive on in_*: in_tuser carries the operation code and
// in_tdata the two raw operands. Each input word yields exactly one output
// word on out_*: the raw result and the status flags in out_tdata.
// Every operation runs through the same pipeline, so results leave in
// order. The pipeline holds an operand stage, two multiplier stages,
// the divider, a chain of 40 one-bit restoring cells (32 integer plus
// 8 fraction quotient bits), and the rounding/output stage.
// Throughput is one word per cycle while the pipeline is not stalled.
// When the receiver holds out_tready low with a word waiting, the whole
// pipeline freezes and in_tready drops in the same cycle; it resumes as
// soon as the waiting word is taken.
// Reset clears all valid bits; the pipeline is empty and ready afterward.
module fixed_point_q24_8_alu (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // operand_a[31:0], operand_b[63:32]
  input  logic [3:0]  in_tuser,   // func[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // result[31:0], less, equal, greater,
                                  // overflow, divide_by_zero, zero fill
);

  localparam int DW = fpa_pkg::DATA_W;

  logic en;
  logic signed [DW-1:0] op_a;
  logic signed [DW-1:0] op_b;
  logic [DW-1:0]        mag_a;
  logic [DW-1:0]        mag_b;
  logic [DW:0]          sat;
  fpa_pkg::cell_t s0_nxt, s0_r, m1_r, m2_r, m2_nxt;
  logic [63:0]          prod_r;
  logic [63:0]          prod_rnd;
  logic [DW:0]          mul_sat;
  fpa_pkg::cell_t chain [fpa_pkg::NUM_W+1];
  fpa_pkg::cell_t last;
  logic                 round_up;
  logic [fpa_pkg::NUM_W:0] q_rnd;
  logic [DW:0]          div_sat;
  logic                 out_valid_r;
  logic [fpa_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // The pipeline moves unless a finished word is waiting.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Operand stage: simple operations finish here, divide sets up the chain.
  always_comb begin
    op_a   = signed'(in_tdata[DW-1:0]);
    op_b   = signed'(in_tdata[2*DW-1:DW]);
    mag_a  = op_a[DW-1] ? DW'(-op_a) : op_a;
    mag_b  = op_b[DW-1] ? DW'(-op_b) : op_b;
    sat    = '0;
    s0_nxt = '0;
    s0_nxt.valid = in_tvalid;
    s0_nxt.func  = in_tuser;
    s0_nxt.neg   = op_a[DW-1] ^ op_b[DW-1];
    s0_nxt.den   = mag_b;
    s0_nxt.quo   = {mag_a, {fpa_pkg::FRAC_W{1'b0}}};
    case (in_tuser)
      fpa_pkg::FN_ADD: begin
        sat = fpa_pkg::sat_s64(64'(op_a) + 64'(op_b));
      end
      fpa_pkg::FN_SUB: begin
        sat = fpa_pkg::sat_s64(64'(op_a) - 64'(op_b));
      end
      fpa_pkg::FN_DIV: begin
        if (op_b == '0) begin
          s0_nxt.dz = 1'b1;
          if (op_a > 0) begin
            sat = {1'b0, fpa_pkg::MAX_VAL};
          end else if (op_a < 0) begin
            sat = {1'b0, fpa_pkg::MIN_VAL};
          end
        end
      end
      fpa_pkg::FN_CMP: begin
        s0_nxt.lt = op_a < op_b;
        s0_nxt.eq = op_a == op_b;
        s0_nxt.gt = op_a > op_b;
      end
      fpa_pkg::FN_MIN: sat = {1'b0, (op_a < op_b) ? op_a : op_b};
      fpa_pkg::FN_MAX: sat = {1'b0, (op_a > op_b) ? op_a : op_b};
      fpa_pkg::FN_INC: sat = fpa_pkg::sat_s64(64'(op_a) + 64'sd1);
      fpa_pkg::FN_DEC: sat = fpa_pkg::sat_s64(64'(op_a) - 64'sd1);
      fpa_pkg::FN_FROM_INT: begin
        sat = fpa_pkg::sat_s64(64'(op_a) <<< fpa_pkg::FRAC_W);
      end
      fpa_pkg::FN_TO_INT: sat = {1'b0, DW'(op_a >>> fpa_pkg::FRAC_W)};
      default: sat = '0;
    endcase
    s0_nxt.ovf = sat[DW];
    s0_nxt.res = sat[DW-1:0];
  end

  // Multiplier rounding and saturation.
  always_comb begin
    prod_rnd = (prod_r + fpa_pkg::MUL_HALF) >> fpa_pkg::FRAC_W;
    mul_sat  = fpa_pkg::sat_mag(m1_r.neg, prod_rnd);
    m2_nxt   = m1_r;
    if (m1_r.func == fpa_pkg::FN_MUL) begin
      m2_nxt.ovf = mul_sat[DW];
      m2_nxt.res = mul_sat[DW-1:0];
    end
  end

  // Operand register and the two multiplier stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
      m1_r.valid <= 1'b0;
      m2_r.valid <= 1'b0;
    end else if (en) begin
      s0_r   <= s0_nxt;
      m1_r   <= s0_r;
      prod_r <= 64'(s0_r.quo[fpa_pkg::NUM_W-1:fpa_pkg::FRAC_W]) * 64'(s0_r.den);
      m2_r   <= m2_nxt;
    end
  end

  // Divider chain, one quotient bit per cell.
  assign chain[0] = m2_r;
  for (genvar i = 0; i < fpa_pkg::NUM_W; i++) begin : g_div
    fpa_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .cell_in (chain[i]),
      .cell_out(chain[i+1])
    );
  end
  assign last = chain[fpa_pkg::NUM_W];

  // Divide rounding, then the output word.
  always_comb begin
    round_up = {last.rem, 1'b0} >= {1'b0, last.den};
    q_rnd    = {1'b0, last.quo} + (fpa_pkg::NUM_W+1)'(round_up);
    div_sat  = fpa_pkg::sat_mag(last.neg, 64'(q_rnd));
    out_data_nxt = {3'b000, last.dz, last.ovf, last.gt, last.eq, last.lt, last.res};
    if (last.func == fpa_pkg::FN_DIV && !last.dz) begin
      out_data_nxt = {3'b000, 1'b0, div_sat[DW], 3'b000, div_sat[DW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
      out_data_r  <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/fpa_div_cell.sv =====
// One step of restoring division: shifts in one numerator bit and
// produces one quotient bit. Everything else in the word passes along.
module fpa_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  fpa_pkg::cell_t cell_in,
  output fpa_pkg::cell_t cell_out
);

  fpa_pkg::cell_t cell_r;
  fpa_pkg::cell_t cell_nxt;
  logic [fpa_pkg::DATA_W:0] trial;
  logic                     fits;

  // Trial subtract of the divisor from the shifted partial remainder.
  always_comb begin
    trial    = {cell_in.rem, cell_in.quo[fpa_pkg::NUM_W-1]};
    fits     = trial >= {1'b0, cell_in.den};
    cell_nxt = cell_in;
    if (fits) begin
      cell_nxt.rem = fpa_pkg::DATA_W'(trial - {1'b0, cell_in.den});
    end else begin
      cell_nxt.rem = trial[fpa_pkg::DATA_W-1:0];
    end
    cell_nxt.quo = {cell_in.quo[fpa_pkg::NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_out = cell_r;

  // The partial remainder always stays below a nonzero divisor.
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_r.valid && cell_r.den != '0) |-> (cell_r.rem < cell_r.den))
    else $error("partial remainder not below divisor");

  // A word advances one cell whenever the pipeline moves.
  a_valid_moves: assert property (@(posedge clk)
    (rst_n && en) |=> (cell_r.valid == $past(cell_in.valid)))
    else $error("valid bit lost or invented in divider cell");

  // A stalled cell keeps its word.
  a_valid_holds: assert property (@(posedge clk)
    (rst_n && !en) |=> $stable(cell_r.valid))
    else $error("valid bit changed during stall");

endmodule
